### sv/qar_pkg.sv
// shared constants and tables for the quaternion axis-angle rotator
// no dependencies
package qar_pkg;

    localparam int QAR_COORD_WIDTH = 32;
    localparam int QAR_ANGLE_WIDTH = 16;
    localparam int QAR_AXIS_WIDTH  = 16;
    localparam int QAR_CORDIC_STEPS = 24;
    localparam logic [33:0] QAR_CORDIC_GAIN = 34'sd652032874;

    // hamilton product sign mask, bit 4*i+j set when term a[j]*b[i^j] subtracts
    localparam logic [15:0] QAR_HAM_NEG = 16'b0100_0010_1000_1110;

    function automatic logic [31:0] qar_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### sv/qar_cordic.sv
// pipelined rotation-mode cordic, one iteration per register stage
// depends on qar_pkg
module qar_cordic #(
    parameter int ANGLE_WIDTH = qar_pkg::QAR_ANGLE_WIDTH,
    parameter int QF          = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_valid,
    output logic signed [QF+1:0]          o_cos,
    output logic signed [QF+1:0]          o_sin
);
    localparam int N = qar_pkg::QAR_CORDIC_STEPS;

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic               r_v [0:N];

    // half angle, 2^32 per turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0] <= qar_pkg::QAR_CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= 34'(i_angle) <<< (31 - ANGLE_WIDTH);
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [33:0] w_dx, w_dy, w_at;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        assign w_at = $signed({2'b00, qar_pkg::qar_atan(5'(i))});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - w_at;
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + w_at;
                end
            end
        end
    end

    logic signed [33:0] w_c, w_s;
    assign w_c     = r_x[N] >>> (30 - QF);
    assign w_s     = r_y[N] >>> (30 - QF);
    assign o_cos   = w_c[QF+1:0];
    assign o_sin   = w_s[QF+1:0];
    assign o_valid = r_v[N];

endmodule

### sv/qar_hprod.sv
// two-stage hamilton product: registered partial products, then sum and shift
// depends on qar_pkg
module qar_hprod #(
    parameter int AW = 29,
    parameter int BW = 32,
    parameter int SH = 24,
    parameter int OW = AW + BW + 2 - SH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_a [4],
    input  logic signed [BW-1:0] i_b [4],
    output logic                 o_valid,
    output logic signed [OW-1:0] o_r [4]
);
    localparam int PW = AW + BW;

    logic signed [PW-1:0] r_prod [16];
    logic                 r_v1;
    logic                 r_v2;
    logic signed [OW-1:0] r_r [4];
    logic signed [PW+1:0] w_sum [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[4*i+j] <= PW'(i_a[j]) * PW'(i_b[i ^ j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sum[i] = '0;
            for (int j = 0; j < 4; j++) begin
                if (qar_pkg::QAR_HAM_NEG[4*i+j]) begin
                    w_sum[i] = w_sum[i] - (PW+2)'(r_prod[4*i+j]);
                end else begin
                    w_sum[i] = w_sum[i] + (PW+2)'(r_prod[4*i+j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_r[i] <= OW'(w_sum[i] >>> SH);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_r     = r_r;

endmodule

### sv/quaternion_axis_angle_rotate.sv
// quaternion axis-angle rotator
// throughput one beat per cycle; the whole pipeline advances together and holds on a
// stalled output, so back pressure reaches the input ready in the same cycle
// stages in order: cordic, axis scaling, the two hamilton products, saturation
// synchronous active-low reset clears every valid bit; data registers are not reset
// depends on qar_pkg, qar_cordic, qar_hprod
module quaternion_axis_angle_rotate #(
    parameter int COORD_WIDTH = qar_pkg::QAR_COORD_WIDTH,
    parameter int ANGLE_WIDTH = qar_pkg::QAR_ANGLE_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // point_x, point_y, point_z, angle, axis_x, axis_y, axis_z, zero pad
    input  logic [((3*COORD_WIDTH+ANGLE_WIDTH+48+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // rotated_x, rotated_y, rotated_z, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // saturated
    output logic o_m_axis_tuser
);
    localparam int AXW   = qar_pkg::QAR_AXIS_WIDTH;
    localparam int QF    = ((56 - COORD_WIDTH) < 30) ? (56 - COORD_WIDTH) : 30;
    localparam int QW    = QF + 5;                    // quaternion component width
    localparam int OW1   = QW + COORD_WIDTH + 2 - QF; // q*p component width
    localparam int OW2   = OW1 + QW + 2 - QF;         // (q*p)*qi component width
    localparam int CDLY  = qar_pkg::QAR_CORDIC_STEPS + 1;
    localparam int OUT_W = ((3*COORD_WIDTH+7)/8)*8;
    localparam int AOFF  = 3*COORD_WIDTH;             // angle offset in tdata

    // single pipeline enable: advance unless a finished beat is stuck at the output
    logic w_en;
    logic r_out_valid;
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---- cordic: cos and sin of half the angle
    logic                  w_cs_valid;
    logic signed [QF+1:0]  w_cos, w_sin;

    qar_cordic #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .QF          (QF)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_angle (i_s_axis_tdata[AOFF +: ANGLE_WIDTH]),
        .o_valid (w_cs_valid),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // ---- side delay lines keep point and axis aligned with the cordic
    logic [3*COORD_WIDTH-1:0] r_pt [0:CDLY];
    logic [3*AXW-1:0]         r_ax [0:CDLY-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pt[0] <= i_s_axis_tdata[3*COORD_WIDTH-1:0];
            r_ax[0] <= i_s_axis_tdata[AOFF+ANGLE_WIDTH +: 3*AXW];
            for (int k = 1; k <= CDLY; k++) begin
                r_pt[k] <= r_pt[k-1];
            end
            for (int k = 1; k < CDLY; k++) begin
                r_ax[k] <= r_ax[k-1];
            end
        end
    end

    // ---- axis scaling: q = (c, (s*axis) >> 14)
    logic                 r_q_valid;
    logic signed [QW-1:0] r_q [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (w_en) begin
            r_q_valid <= w_cs_valid;
        end
        if (w_en) begin
            r_q[0] <= QW'(w_cos);
            for (int k = 0; k < 3; k++) begin
                r_q[k+1] <= QW'(((QF+AXW+2)'(w_sin) *
                    (QF+AXW+2)'($signed(r_ax[CDLY-1][k*AXW +: AXW]))) >>> 14);
            end
        end
    end

    // ---- first product q*p, p = (0, point)
    logic signed [COORD_WIDTH-1:0] w_p [4];
    logic                          w_qp_valid;
    logic signed [OW1-1:0]         w_qp [4];

    always_comb begin
        w_p[0] = '0;
        for (int k = 0; k < 3; k++) begin
            w_p[k+1] = $signed(r_pt[CDLY][k*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    qar_hprod #(
        .AW (QW),
        .BW (COORD_WIDTH),
        .SH (QF),
        .OW (OW1)
    ) u_hprod_qp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_q_valid),
        .i_a     (r_q),
        .i_b     (w_p),
        .o_valid (w_qp_valid),
        .o_r     (w_qp)
    );

    // conjugate of q travels two stages to meet q*p
    logic signed [QW-1:0] r_qi1 [4];
    logic signed [QW-1:0] r_qi2 [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qi1[0] <= r_q[0];
            for (int k = 1; k < 4; k++) begin
                r_qi1[k] <= -r_q[k];
            end
            r_qi2 <= r_qi1;
        end
    end

    // ---- second product (q*p)*conj(q)
    logic                  w_r_valid;
    logic signed [OW2-1:0] w_r [4];

    qar_hprod #(
        .AW (OW1),
        .BW (QW),
        .SH (QF),
        .OW (OW2)
    ) u_hprod_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qp_valid),
        .i_a     (w_qp),
        .i_b     (r_qi2),
        .o_valid (w_r_valid),
        .o_r     (w_r)
    );

    // ---- saturation to the coordinate range and output register
    logic [3*COORD_WIDTH-1:0] n_res;
    logic                     n_sat;
    logic [3*COORD_WIDTH-1:0] r_res;
    logic                     r_sat;

    always_comb begin
        n_sat = 1'b0;
        n_res = '0;
        for (int k = 0; k < 3; k++) begin
            // overflow when the bits above the sign do not all match it
            if (w_r[k+1][OW2-1:COORD_WIDTH-1] != {(OW2-COORD_WIDTH+1){1'b0}} &&
                w_r[k+1][OW2-1:COORD_WIDTH-1] != {(OW2-COORD_WIDTH+1){1'b1}}) begin
                n_sat = 1'b1;
                n_res[k*COORD_WIDTH +: COORD_WIDTH] = w_r[k+1][OW2-1] ?
                    {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end else begin
                n_res[k*COORD_WIDTH +: COORD_WIDTH] = w_r[k+1][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_r_valid;
        end
        if (w_en) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_res);
    assign o_m_axis_tuser  = r_sat;

    // ---- checks
    // a clipped beat carries at least one component at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |->
            (r_res[COORD_WIDTH-2:0] == {(COORD_WIDTH-1){1'b1}} ||
             r_res[COORD_WIDTH-2:0] == {(COORD_WIDTH-1){1'b0}} ||
             r_res[2*COORD_WIDTH-2:COORD_WIDTH] == {(COORD_WIDTH-1){1'b1}} ||
             r_res[2*COORD_WIDTH-2:COORD_WIDTH] == {(COORD_WIDTH-1){1'b0}} ||
             r_res[3*COORD_WIDTH-2:2*COORD_WIDTH] == {(COORD_WIDTH-1){1'b1}} ||
             r_res[3*COORD_WIDTH-2:2*COORD_WIDTH] == {(COORD_WIDTH-1){1'b0}}))
        else $error("saturated flag without a clipped component");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_q_valid))
        else $error("valid bits survived reset");

    // a held output freezes the axis-scaling stage feeding the multipliers
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(r_q_valid))
        else $error("pipeline moved during a stall");

endmodule
